/* rtl/tsm_pkg.sv */
// Shared types, constants and helper functions of the substring match finder.
// No dependencies; every other file of the block imports this package.
package tsm_pkg;

	// Field and storage sizes
	localparam int MAX_PATTERN    = 16;
	localparam int CHAR_BITS      = 16;
	localparam int LINE_BITS      = 20;
	localparam int COL_BITS       = 16;
	localparam int MNUM_BITS      = 20;
	localparam int LEN_BITS       = 5;
	localparam int WIN_DEPTH      = MAX_PATTERN + 1;
	localparam int WIN_IDX_BITS   = $clog2(WIN_DEPTH);
	localparam int PAT_WORDS      = 4;
	localparam int CHARS_PER_WORD = 4;
	localparam int PAT_CHARS      = PAT_WORDS * CHARS_PER_WORD;
	localparam int PAT_IDX_BITS   = $clog2(PAT_CHARS);
	localparam int CFG_BITS       = 64;
	localparam int CFG_IDX_BITS   = 3;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_WORD0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_WORD1 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_WORD2 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_WORD3 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAT_LEN   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CASE_SENS = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_WORD = 3'd6;

	// ASCII codes used by case folding and word-character classification
	localparam logic [CHAR_BITS-1:0] ASCII_0          = 16'h0030;
	localparam logic [CHAR_BITS-1:0] ASCII_9          = 16'h0039;
	localparam logic [CHAR_BITS-1:0] ASCII_UPPER_A    = 16'h0041;
	localparam logic [CHAR_BITS-1:0] ASCII_UPPER_Z    = 16'h005A;
	localparam logic [CHAR_BITS-1:0] ASCII_LOWER_A    = 16'h0061;
	localparam logic [CHAR_BITS-1:0] ASCII_LOWER_Z    = 16'h007A;
	localparam logic [CHAR_BITS-1:0] ASCII_UNDERSCORE = 16'h005F;
	localparam logic [CHAR_BITS-1:0] ASCII_CASE_DELTA = 16'h0020;

	typedef logic [CHAR_BITS-1:0] char_t;
	typedef logic [LINE_BITS-1:0] line_t;
	typedef logic [COL_BITS-1:0]  col_t;
	typedef logic [MNUM_BITS-1:0] mnum_t;
	typedef logic [LEN_BITS-1:0]  len_t;

	// Live configuration seen by the match engine
	typedef struct packed {
		logic [PAT_CHARS-1:0][CHAR_BITS-1:0] pat;
		len_t                                len;
		logic                                case_sens;
		logic                                whole_word;
	} cfg_t;

	// One reported match
	typedef struct packed {
		line_t line_number;
		col_t  start_column;
		col_t  end_column;
		mnum_t match_number;
	} result_t;

	// One queued request: the results caused by one text item
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	// Map ASCII A-Z to a-z unless comparing exactly
	function automatic char_t fold(input char_t c, input logic case_sens);
		if (!case_sens && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
			return c + ASCII_CASE_DELTA;
		return c;
	endfunction

	// Letter, digit or underscore
	function automatic logic is_word_char(input char_t c);
		return (c >= ASCII_0 && c <= ASCII_9) ||
			(c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) ||
			(c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) ||
			(c == ASCII_UNDERSCORE);
	endfunction

endpackage

/* rtl/tsm_if.sv */
// Valid/ready channel interfaces for text input and match results.
// Depends on tsm_pkg for field widths.
interface tsm_in_if;
	import tsm_pkg::*;
	logic  valid;
	logic  ready;
	char_t character;
	logic  has_char;
	logic  end_of_line;
	logic  start_of_text;

	modport source (output valid, character, has_char, end_of_line, start_of_text,
		input ready);
	modport sink (input valid, character, has_char, end_of_line, start_of_text,
		output ready);
endinterface

interface tsm_out_if;
	import tsm_pkg::*;
	logic  valid;
	logic  ready;
	line_t line_number;
	col_t  start_column;
	col_t  end_column;
	mnum_t match_number;
	logic  last_of_run;

	modport source (output valid, line_number, start_column, end_column, match_number,
		last_of_run, input ready);
	modport sink (input valid, line_number, start_column, end_column, match_number,
		last_of_run, output ready);
endinterface

/* rtl/tsm_front.sv */
// Front end: accepts text items, keeps the character window and the line/column/match
// counters, classifies each item and pushes its results (zero, one or two) as one request.
// Depends on tsm_pkg and tsm_in_if.
module tsm_front (
	input  logic            clk,
	input  logic            arst_n,
	input  tsm_pkg::cfg_t   cfg,
	tsm_in_if.sink          text_in,
	output logic            push_valid,
	input  logic            push_ready,
	output tsm_pkg::entry_t push_entry
);
	import tsm_pkg::*;

	logic [WIN_DEPTH-1:0][CHAR_BITS-1:0] win_q, win0, win1;
	logic [PAT_CHARS-1:0][CHAR_BITS-1:0] apat;
	col_t    col_q, col0, col1, col_d, start_new;
	line_t   line_q, line0, line_d;
	mnum_t   mc_q, mc0, mc_p1, mc_p2, mc_d;
	logic    pv_q, pv0, pv1, pv_d;
	col_t    ps_q, ps0, ps1;
	len_t    elen, idx;
	logic    acc, hc, match, before_bad;
	logic    r_a, r_b, r_c;
	result_t res_a, res_b, res_c, res_x;
	logic [1:0] n_res;

	assign acc            = text_in.valid && text_in.ready;
	assign text_in.ready  = push_ready;
	assign hc             = text_in.has_char;

	// Pattern aligned to the window: window slot i holds pattern char len-1-i
	always_comb begin
		elen = (cfg.len > LEN_BITS'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN) : cfg.len;
		for (int i = 0; i < PAT_CHARS; i++) begin
			idx = elen - LEN_BITS'(1) - LEN_BITS'(i);
			apat[i] = (LEN_BITS'(i) < elen) ? cfg.pat[idx[PAT_IDX_BITS-1:0]] : '0;
		end
	end

	// Item evaluation
	always_comb begin
		// text start clears before the item
		win0  = text_in.start_of_text ? '0 : win_q;
		col0  = text_in.start_of_text ? '0 : col_q;
		line0 = text_in.start_of_text ? '0 : line_q;
		mc0   = text_in.start_of_text ? '0 : mc_q;
		pv0   = text_in.start_of_text ? 1'b0 : pv_q;
		ps0   = text_in.start_of_text ? '0 : ps_q;

		// a new character decides the pending match first
		r_a = hc && pv0 && !is_word_char(text_in.character);
		pv1 = hc ? 1'b0 : pv0;
		ps1 = ps0;

		win1 = hc ? {win0[WIN_DEPTH-2:0], text_in.character} : win0;
		col1 = (hc && col0 != '1) ? col0 + 1'b1 : col0;

		// window compare
		match = hc && (elen != '0) && (col1 >= COL_BITS'(elen));
		for (int i = 0; i < PAT_CHARS; i++) begin
			if (LEN_BITS'(i) < elen &&
				fold(win1[i], cfg.case_sens) != fold(apat[i], cfg.case_sens))
				match = 1'b0;
		end
		start_new  = col1 - COL_BITS'(elen);
		before_bad = (col1 > COL_BITS'(elen)) && is_word_char(win1[elen]);

		r_b = 1'b0;
		if (match) begin
			if (cfg.whole_word) begin
				if (!before_bad) begin
					pv1 = 1'b1;
					ps1 = start_new;
				end
			end else begin
				r_b = 1'b1;
			end
		end

		// line end confirms a pending match
		r_c  = text_in.end_of_line && pv1;
		pv_d = text_in.end_of_line ? 1'b0 : pv1;
		line_d = (text_in.end_of_line && line0 != '1) ? line0 + 1'b1 : line0;
		col_d  = text_in.end_of_line ? '0 : col1;

		// result ordering: char decision, new match, line end
		mc_p1 = (mc0 != '1) ? mc0 + 1'b1 : mc0;
		mc_p2 = (mc_p1 != '1) ? mc_p1 + 1'b1 : mc_p1;
		res_a = '{line_number: line0, start_column: ps0, end_column: col0, match_number: '0};
		res_b = '{line_number: line0, start_column: start_new, end_column: col1,
			match_number: '0};
		res_c = '{line_number: line0, start_column: ps1, end_column: col1, match_number: '0};
		res_x = r_b ? res_b : res_c;
		n_res = 2'(r_a) + 2'(r_b) + 2'(r_c);

		push_entry.two = (n_res == 2'd2);
		push_entry.r0  = r_a ? res_a : res_x;
		push_entry.r0.match_number = mc0;
		push_entry.r1  = res_x;
		push_entry.r1.match_number = mc_p1;

		case (n_res)
			2'd0:    mc_d = mc0;
			2'd1:    mc_d = mc_p1;
			default: mc_d = mc_p2;
		endcase
	end

	assign push_valid = text_in.valid && (n_res != 2'd0);

	// Stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			col_q  <= '0;
			line_q <= '0;
			mc_q   <= '0;
			pv_q   <= 1'b0;
			ps_q   <= '0;
		end else if (acc) begin
			win_q  <= win1;
			col_q  <= col_d;
			line_q <= line_d;
			mc_q   <= mc_d;
			pv_q   <= pv_d;
			ps_q   <= ps1;
		end
	end

endmodule

/* rtl/tsm_queue.sv */
// Back end: short request queue between the front end and the result channel;
// unpacks each request into one or two results and marks the last one.
// Depends on tsm_pkg and tsm_out_if.
module tsm_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  tsm_pkg::entry_t push_entry,
	tsm_out_if.source       match_out
);
	import tsm_pkg::*;

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	entry_t              mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                sub_q;
	logic                push, pop, out_acc, last;
	entry_t              head;
	result_t             res;

	assign push_ready = (count_q != CNT_BITS'(DEPTH));
	assign push       = push_valid && push_ready;

	// Head request, first or second result
	assign head     = mem_q[rd_ptr_q];
	assign last     = !head.two || sub_q;
	assign res      = sub_q ? head.r1 : head.r0;
	assign out_acc  = match_out.valid && match_out.ready;
	assign pop      = out_acc && last;

	assign match_out.valid        = (count_q != '0);
	assign match_out.line_number  = res.line_number;
	assign match_out.start_column = res.start_column;
	assign match_out.end_column   = res.end_column;
	assign match_out.match_number = res.match_number;
	assign match_out.last_of_run  = last;

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	// Pointers, fill count and result select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
			if (out_acc)
				sub_q <= !last;
		end
	end

endmodule

/* rtl/text_substring_match_finder.sv */
// Substring match finder, top level: configuration registers, front end, result queue.
// Depends on tsm_pkg, tsm_if, tsm_front and tsm_queue.
//
// Usage:
//   text_in   : one text item per request (character, has_char, end_of_line,
//               start_of_text), valid/ready handshake.
//   match_out : one match per request (line, start/end column, match number,
//               last_of_run set on the final result of an item).
//   cfg_we/cfg_index/cfg_wdata : register writes, only while the block is idle;
// the user keeps to this, the block does not enforce it. Each item is evaluated in
// the cycle it is accepted against a 17-character window; its results are queued and
// reach match_out behind any earlier results. Throughput: one item per cycle while
// the queue has room; an item with two results holds the output port until both are
// taken, so the result port sets the sustained rate when matches are dense. The queue
// holds QUEUE_DEPTH items' results. When match_out stalls, text_in keeps taking items
// until the queue is full, then drops ready. Reset clears the window, counters, pending
// match and the queue, and sets all registers to zero (no pattern, so no matches).
module text_substring_match_finder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tsm_in_if.sink                               text_in,
	tsm_out_if.source                            match_out,
	input  logic                                 cfg_we,
	input  logic [tsm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tsm_pkg::CFG_BITS-1:0]         cfg_wdata
);
	import tsm_pkg::*;

	logic [PAT_WORDS-1:0][CFG_BITS-1:0] pat_word_q;
	len_t   pat_len_q;
	logic   case_sens_q;
	logic   whole_word_q;
	cfg_t   cfg;
	logic   push_valid, push_ready;
	entry_t push_entry;
	logic   out_acc;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_word_q   <= '0;
			pat_len_q    <= '0;
			case_sens_q  <= 1'b0;
			whole_word_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_WORD0:  pat_word_q[0] <= cfg_wdata;
				REG_PAT_WORD1:  pat_word_q[1] <= cfg_wdata;
				REG_PAT_WORD2:  pat_word_q[2] <= cfg_wdata;
				REG_PAT_WORD3:  pat_word_q[3] <= cfg_wdata;
				REG_PAT_LEN:    pat_len_q     <= cfg_wdata[LEN_BITS-1:0];
				REG_CASE_SENS:  case_sens_q   <= cfg_wdata[0];
				REG_WHOLE_WORD: whole_word_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg.pat        = pat_word_q;
	assign cfg.len        = pat_len_q;
	assign cfg.case_sens  = case_sens_q;
	assign cfg.whole_word = whole_word_q;

	tsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.text_in    (text_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	tsm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.match_out  (match_out)
	);

	assign out_acc = match_out.valid && match_out.ready;

	// The second result of an item is available right after the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !match_out.last_of_run |=> match_out.valid)
		else $error("second result of an item not available");

	// Both results of one item carry the same line
	a_pair_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !match_out.last_of_run |=>
			match_out.line_number == $past(match_out.line_number))
		else $error("results of one item differ in line");

	// A match never ends before it starts
	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		match_out.valid |-> match_out.end_column >= match_out.start_column)
		else $error("end column below start column");

endmodule
